// File: src/fea_pkg.sv
package fea_pkg;

  localparam int unsigned MaxExtentsDef = 64;
  localparam int unsigned BlockBytesDef = 512;
  localparam int unsigned AddrW = 31;

  localparam logic [1:0] FUNC_INIT  = 2'd0;
  localparam logic [1:0] FUNC_BEST  = 2'd1;
  localparam logic [1:0] FUNC_NEAR  = 2'd2;
  localparam logic [1:0] FUNC_EXACT = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Request word as decoded and held for the scan and commit logic.
  typedef struct packed {
    logic [1:0]  func;
    logic [32:0] size;
    logic [32:0] a;
    logic [32:0] b;
  } req_t;

  // Commit command broadcast along the cell row.
  typedef struct packed {
    logic        init;
    logic        set_low;
    logic        split;
    logic [32:0] low_val;
    logic [32:0] cut_lo;
    logic [32:0] cut_hi;
  } cmd_t;

endpackage

// File: src/fea_cell.sv
module fea_cell (
  input  logic                    clk,
  input  logic                    scan_en,
  input  logic                    cmd_en,
  input  logic                    sel_here,
  input  logic                    shift_here,
  input  logic                    prev_sel,
  input  fea_pkg::cmd_t           cmd,
  input  logic                    is_first,
  input  logic [fea_pkg::AddrW-1:0] prev_low,
  input  logic [fea_pkg::AddrW-1:0] prev_high,
  input  logic [fea_pkg::AddrW-1:0] next_low,
  input  logic [fea_pkg::AddrW-1:0] next_high,
  output logic [fea_pkg::AddrW-1:0] low,
  output logic [fea_pkg::AddrW-1:0] high
);
  import fea_pkg::*;

  logic [AddrW-1:0] low_r, high_r, low_nxt, high_nxt;

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (scan_en) begin
      low_nxt  = next_low;
      high_nxt = next_high;
    end else if (cmd_en) begin
      if (cmd.init) begin
        if (is_first) begin
          low_nxt  = '0;
          high_nxt = cmd.low_val[AddrW-1:0];
        end
      end else if (sel_here) begin
        if (cmd.split) begin
          high_nxt = cmd.cut_lo[AddrW-1:0];
        end else if (cmd.set_low) begin
          low_nxt = cmd.low_val[AddrW-1:0];
        end
      end else if (cmd.split && prev_sel) begin
        low_nxt  = cmd.cut_hi[AddrW-1:0];
        high_nxt = prev_high;
      end else if (cmd.split && shift_here) begin
        low_nxt  = prev_low;
        high_nxt = prev_high;
      end
    end
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    high_r <= high_nxt;
  end

  assign low  = low_r;
  assign high = high_r;
endmodule

// File: src/free_extent_allocator.sv
// Free-extent allocator. One request word enters on in_* (tdata: func,
// request_size, addr_a, addr_b from bit 0 up); one result word leaves on
// out_* (tdata: status, granted_addr, lowest_free from bit 0 up).
// The free table is a ring of MAX_EXTENTS cells that rotate one place per
// cycle while scanning. A request rotates the ring once fully while a
// single comparator looks at the entry passing slot 0, then commits, and
// the result word is registered and offered on out_*. An init request
// skips the rotation and goes straight to the commit.
// Only one request is in service; in_tready is low from acceptance until
// the result word leaves the output register. A stalled out_tready holds
// the result and keeps the block from taking the next request.
// After reset the table is empty: every allocation answers no fit with
// lowest free address 0 until an init request arrives. Table entries need
// no clearing, since only entries below the count are ever read.
module free_extent_allocator #(
  parameter int unsigned MAX_EXTENTS = fea_pkg::MaxExtentsDef,
  parameter int unsigned BLOCK_BYTES = fea_pkg::BlockBytesDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // func, request_size, addr_a, addr_b, pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata   // status, granted_addr, lowest_free
);
  import fea_pkg::*;

  localparam int unsigned IW = $clog2(MAX_EXTENTS);
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned RW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_OUT} state_t;

  state_t           state_r;
  req_t             req_r;
  logic [CW-1:0]    count_r;
  logic [IW:0]      step_r;
  logic             found_r;
  logic [IW-1:0]    sel_r;
  logic [32:0]      best_len_r;
  logic [32:0]      sel_low_r, sel_high_r;
  logic             out_valid_r;
  logic [1:0]       st_r;
  logic [AddrW-1:0] addr_r, lowf_r;

  logic [AddrW-1:0] lows [MAX_EXTENTS];
  logic [AddrW-1:0] highs[MAX_EXTENTS];

  function automatic logic [32:0] round_up(input logic [32:0] v);
    logic [32:0] q;
    begin
      q = (v + 33'(BLOCK_BYTES - 1)) / 33'(BLOCK_BYTES);
      round_up = 33'(q * 33'(BLOCK_BYTES));
    end
  endfunction

  // Decode request.
  logic [1:0]  in_func;
  logic [32:0] in_size, in_a, in_b;
  assign in_func = in_tdata[1:0];
  assign in_size = (in_func == FUNC_BEST || in_func == FUNC_NEAR)
                   ? round_up({2'b0, in_tdata[32:2]}) : {2'b0, in_tdata[32:2]};
  assign in_a    = (in_func == FUNC_NEAR) ? round_up({2'b0, in_tdata[63:33]})
                                          : {2'b0, in_tdata[63:33]};
  assign in_b    = {2'b0, in_tdata[94:64]};

  // Comparator on the entry passing slot 0.
  logic [32:0] lo, hi, len;
  logic        in_range, hit_best, hit_near, hit_exact, hit;
  assign lo  = {2'b0, lows[0]};
  assign hi  = {2'b0, highs[0]};
  assign len = (hi >= lo) ? hi - lo : '0;
  assign in_range = (step_r[IW-1:0] < count_r[IW-1:0]) ||
                    (CW > IW && count_r == CW'(MAX_EXTENTS));
  assign hit_best  = len >= req_r.size && (!found_r || len < best_len_r);
  assign hit_near  = !found_r &&
    ((lo <= req_r.a && hi > req_r.a && hi - req_r.a >= req_r.size) ||
     (lo > req_r.a && hi >= lo && len >= req_r.size));
  assign hit_exact = !found_r && lo <= req_r.a && hi >= req_r.b;
  always_comb begin
    case (req_r.func)
      FUNC_BEST:  hit = hit_best;
      FUNC_NEAR:  hit = hit_near;
      FUNC_EXACT: hit = hit_exact;
      default:    hit = 1'b0;
    endcase
  end

  // Commit decision.
  logic       do_split, full, ok;
  cmd_t       cmd;
  logic [1:0] st_nxt;
  always_comb begin
    cmd      = '0;
    do_split = 1'b0;
    ok       = found_r;
    case (req_r.func)
      FUNC_INIT: begin
        cmd.init    = 1'b1;
        cmd.low_val = req_r.size;
        ok          = 1'b1;
      end
      FUNC_BEST: begin
        cmd.set_low = 1'b1;
        cmd.low_val = sel_low_r + req_r.size;
      end
      FUNC_NEAR: begin
        do_split    = sel_low_r < req_r.a;
        cmd.set_low = 1'b1;
        cmd.low_val = sel_low_r + req_r.size;
        cmd.cut_lo  = req_r.a;
        cmd.cut_hi  = req_r.a + req_r.size;
      end
      FUNC_EXACT: begin
        ok          = found_r && req_r.a <= req_r.b;
        do_split    = sel_low_r != req_r.a;
        cmd.set_low = 1'b1;
        cmd.low_val = req_r.b;
        cmd.cut_lo  = req_r.a;
        cmd.cut_hi  = req_r.b;
      end
      default: ;
    endcase
    full      = ok && do_split && count_r >= CW'(MAX_EXTENTS);
    cmd.split = ok && do_split && !full;
    if (!ok || full) begin
      cmd.set_low = 1'b0;
    end
    st_nxt = !ok ? ST_NOFIT : (full ? ST_FULL : ST_OK);
  end

  logic scan_en, cmd_en;
  assign scan_en = (state_r == S_SCAN);
  assign cmd_en  = (state_r == S_COMMIT);

  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    fea_cell u_cell (
      .clk        (clk),
      .scan_en    (scan_en),
      .cmd_en     (cmd_en),
      .sel_here   (sel_r == IW'(i)),
      .shift_here (IW'(i) > sel_r && IW'(i) <= count_r[IW-1:0]),
      .prev_sel   (i > 0 && sel_r == IW'((i + MAX_EXTENTS - 1) % MAX_EXTENTS)),
      .cmd        (cmd),
      .is_first   (i == 0),
      .prev_low   (lows[(i + MAX_EXTENTS - 1) % MAX_EXTENTS]),
      .prev_high  (highs[(i + MAX_EXTENTS - 1) % MAX_EXTENTS]),
      .next_low   (lows[(i + 1) % MAX_EXTENTS]),
      .next_high  (highs[(i + 1) % MAX_EXTENTS]),
      .low        (lows[i]),
      .high       (highs[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      step_r      <= '0;
      sel_r       <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            req_r   <= '{func: in_func, size: in_size, a: in_a, b: in_b};
            found_r <= 1'b0;
            step_r  <= '0;
            sel_r   <= '0;
            state_r <= (in_func == FUNC_INIT) ? S_COMMIT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (in_range && hit) begin
            found_r    <= 1'b1;
            sel_r      <= step_r[IW-1:0];
            best_len_r <= len;
            sel_low_r  <= lo;
            sel_high_r <= hi;
          end
          step_r <= step_r + 1'b1;
          if (step_r == (IW+1)'(MAX_EXTENTS - 1)) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (req_r.func == FUNC_INIT) begin
            count_r <= CW'(1);
          end else if (cmd.split) begin
            count_r <= count_r + 1'b1;
          end
          st_r    <= st_nxt;
          addr_r  <= '0;
          if (st_nxt == ST_OK && req_r.func != FUNC_INIT) begin
            addr_r <= (req_r.func == FUNC_BEST ||
                       (req_r.func == FUNC_NEAR && !do_split))
                      ? sel_low_r[AddrW-1:0] : req_r.a[AddrW-1:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            lowf_r      <= (count_r == '0) ? '0 : lows[0];
          end else if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{sel_high_r, in_tdata[95], RW[0]};

  assign in_tready  = (state_r == S_IDLE) && !unused | (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {lowf_r, addr_r, st_r};
endmodule

// File: src/fea_checker.sv
module fea_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);
  import fea_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input open while result pending");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == ST_OK || out_tdata[1:0] == ST_NOFIT ||
                    out_tdata[1:0] == ST_FULL))
    else $error("bad status");
  a_noaddr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[32:2] == '0)
    else $error("address on failure");
endmodule

bind free_extent_allocator fea_checker u_fea_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// File: dv/tb.sv
module tb;
  import fea_pkg::*;

  localparam int unsigned NEXT = 64;
  localparam int unsigned BLK = 512;

  class extent_board;
    logic [30:0] lo_q[$];
    logic [30:0] hi_q[$];
    logic [63:0] pending[$];
    int unsigned n_fail;
    int unsigned n_seen;

    function void report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %0s: got %h want %h", what, got, want);
      n_fail++;
    endfunction

    function longint unsigned rnd_up(longint unsigned v);
      longint unsigned r;
      r = v % BLK;
      return r ? v + (BLK - r) : v;
    endfunction

    function void split(int i, logic [30:0] c_lo, logic [30:0] c_hi);
      lo_q.insert(i + 1, c_hi);
      hi_q.insert(i + 1, hi_q[i]);
      hi_q[i] = c_lo;
    endfunction

    function void note(logic [1:0] f, logic [30:0] sz, logic [30:0] a, logic [30:0] b);
      logic [1:0] st;
      logic [30:0] ga;
      longint unsigned s, aa, lo, hi, len, best_len;
      int best;
      logic [30:0] lf;
      st = ST_NOFIT;
      ga = '0;
      case (f)
        FUNC_INIT: begin
          lo_q = {31'd0};
          hi_q = {sz};
          st = ST_OK;
        end
        FUNC_BEST: begin
          s = rnd_up(sz);
          best = -1;
          best_len = 0;
          foreach (lo_q[i]) begin
            len = (hi_q[i] >= lo_q[i]) ? hi_q[i] - lo_q[i] : 0;
            if (len >= s && (best < 0 || len < best_len)) begin
              best = i;
              best_len = len;
            end
          end
          if (best >= 0) begin
            st = ST_OK;
            ga = lo_q[best];
            lo_q[best] = 31'(lo_q[best] + s);
          end
        end
        FUNC_NEAR: begin
          aa = rnd_up(a);
          s = rnd_up(sz);
          for (int i = 0; i < lo_q.size(); i++) begin
            lo = lo_q[i];
            hi = hi_q[i];
            if (!((lo <= aa && hi > aa && hi - aa >= s) ||
                  (lo > aa && hi >= lo && hi - lo >= s))) continue;
            if (lo >= aa) begin
              st = ST_OK;
              ga = 31'(lo);
              lo_q[i] = 31'(lo + s);
            end else if (lo_q.size() >= NEXT) begin
              st = ST_FULL;
            end else begin
              split(i, 31'(aa), 31'(aa + s));
              st = ST_OK;
              ga = 31'(aa);
            end
            break;
          end
        end
        default: begin
          if (a <= b) begin
            for (int i = 0; i < lo_q.size(); i++) begin
              if (lo_q[i] > a || hi_q[i] < b) continue;
              if (lo_q[i] == a) begin
                lo_q[i] = b;
                st = ST_OK;
              end else if (lo_q.size() >= NEXT) begin
                st = ST_FULL;
              end else begin
                split(i, a, b);
                st = ST_OK;
              end
              break;
            end
          end
          if (st == ST_OK) ga = a;
        end
      endcase
      lf = lo_q.size() ? lo_q[0] : '0;
      pending.push_back({lf, ga, st});
    endfunction

    function void check(logic [63:0] got);
      logic [63:0] want;
      n_seen++;
      if (pending.size() == 0) begin
        report("unexpected word", got, '0);
        return;
      end
      want = pending.pop_front();
      if (got[1:0] !== want[1:0]) report("status", got[1:0], want[1:0]);
      if (got[32:2] !== want[32:2]) report("granted_addr", got[32:2], want[32:2]);
      if (got[63:33] !== want[63:33]) report("lowest_free", got[63:33], want[63:33]);
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [95:0] in_tdata;
  logic [63:0] out_tdata;
  bit quiet;
  extent_board sb;

  free_extent_allocator DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);
  end

  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      out_tready = quiet || ($urandom_range(99) >= 6);
    end
  end

  task automatic send_req(logic [1:0] f, logic [30:0] sz, logic [30:0] a, logic [30:0] b);
    while (!quiet && $urandom_range(99) < 6) begin
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {1'b0, b, a, sz, f};
    do @(posedge clk); while (!in_tready);
    sb.note(f, sz, a, b);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    while (sb.pending.size() && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  function automatic logic [30:0] rand_addr(logic [30:0] span);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 31'($urandom);
    if (r < 5) return 31'($urandom_range(span / BLK) * BLK);
    return 31'($urandom_range(span));
  endfunction

  initial begin
    logic [30:0] span, sz, a, b;
    logic [1:0] f;
    sb = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    quiet = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_req(FUNC_BEST, 31'd1, 0, 0);
    send_req(FUNC_NEAR, 31'd1, 31'd0, 0);
    send_req(FUNC_EXACT, 0, 31'd0, 31'd0);
    send_req(FUNC_INIT, 31'h7fffffff, 0, 0);
    send_req(FUNC_BEST, 31'h7fffffff, 0, 0);
    send_req(FUNC_NEAR, 31'd1, 31'h7fffffff, 0);
    send_req(FUNC_BEST, 31'd1, 0, 0);
    send_req(FUNC_NEAR, 31'd100, 31'd1000, 0);
    send_req(FUNC_NEAR, 31'd0, 31'd0, 0);
    send_req(FUNC_EXACT, 0, 31'd5000, 31'd4000);
    send_req(FUNC_EXACT, 0, 31'd5000, 31'd6000);
    send_req(FUNC_EXACT, 0, 31'd6000, 31'd6000);
    send_req(FUNC_EXACT, 0, 31'h7ffffffe, 31'h7fffffff);
    send_req(FUNC_INIT, 31'd0, 0, 0);
    send_req(FUNC_BEST, 31'd0, 0, 0);
    send_req(FUNC_INIT, 31'd65536, 0, 0);
    for (int i = 0; i < 70; i++) send_req(FUNC_EXACT, 0, 31'(i * 900 + 10), 31'(i * 900 + 20));
    send_req(FUNC_NEAR, 31'd1, 31'd64000, 0);
    drain();

    for (int i = 0; i < 1650; i++) begin
      if (i % 150 == 0) begin
        span = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(1 << 20));
        send_req(FUNC_INIT, span, 0, 0);
      end
      if (i == 400) drain();
      quiet = (i >= 600 && i < 800);
      f = 2'($urandom_range(3));
      if (f == FUNC_INIT && $urandom_range(3) != 0) f = FUNC_EXACT;
      sz = ($urandom_range(19) == 0) ? 31'($urandom) : 31'($urandom_range(span / 16 + 1));
      a = rand_addr(span);
      b = ($urandom_range(9) == 0) ? rand_addr(span) : 31'(a + $urandom_range(4096));
      send_req(f, f == FUNC_INIT ? span : sz, a, b);
    end
    quiet = 0;
    drain();
    repeat (200) @(negedge clk);
    $display("covered %0d result words over init, best-fit, nearest-after and exact-range",
             sb.n_seen);
    $display("including empty table, reversed ranges, oversized sizes and a full table");
    if (sb.n_fail == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: free_extent_allocator.f
src/fea_pkg.sv
src/fea_cell.sv
src/free_extent_allocator.sv
src/fea_checker.sv
dv/tb.sv
